### rtl/cdfp_pkg.sv
package cdfp_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int DIST_BITS_DEF   = 16;
    localparam int PIXEL_W         = 16;
    localparam int CFG_W           = 11;
    localparam int CFG_IDX_W       = 1;
    localparam int ROW_LIMIT       = 1024;
    localparam int ROW_W           = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS = 1'b0,
        REG_IMAGE_COLS = 1'b1
    } t_cfg_reg;

    // Position of one pixel in the frame, as seen by the distance stage
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_row;
    } t_pos_flags;

endpackage

### rtl/cdfp_line_store.sv
module cdfp_line_store #(
    parameter int DEPTH  = cdfp_pkg::MAX_COLUMNS_DEF,
    parameter int DATA_W = cdfp_pkg::DIST_BITS_DEF,
    parameter int ADDR_W = $clog2(cdfp_pkg::MAX_COLUMNS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write: a same-edge write is not seen, the caller forwards it
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

### rtl/cdfp_raster_ctr.sv
module cdfp_raster_ctr #(
    parameter int MAX_COLUMNS = cdfp_pkg::MAX_COLUMNS_DEF,
    parameter int COL_W       = $clog2(cdfp_pkg::MAX_COLUMNS_DEF)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cdfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cdfp_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_advance,
    output logic [COL_W-1:0]                 o_col,
    output cdfp_pkg::t_pos_flags             o_flags
);
    import cdfp_pkg::*;

    localparam int CNT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam logic [CNT_W-1:0] MAX_COLS_C  = CNT_W'(MAX_COLUMNS);
    localparam logic [CFG_W-1:0] ROW_LIMIT_C = CFG_W'(ROW_LIMIT);

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;
    logic [COL_W-1:0] r_col, n_col, col_c;
    logic [ROW_W-1:0] r_row, n_row, row_c;
    logic [CNT_W-1:0] cols_w, eff_cols;
    logic [CFG_W-1:0] eff_rows;
    logic             last_col, last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(1);
            r_cols <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_ROWS: r_rows <= i_cfg_data;
                REG_IMAGE_COLS: r_cols <= i_cfg_data;
            endcase
        end
    end

    // zero acts as one, oversize acts as the limit
    always_comb begin
        cols_w   = CNT_W'(r_cols);
        eff_cols = (cols_w == '0) ? CNT_W'(1) :
                   ((cols_w > MAX_COLS_C) ? MAX_COLS_C : cols_w);
        eff_rows = (r_rows == '0) ? CFG_W'(1) :
                   ((r_rows > ROW_LIMIT_C) ? ROW_LIMIT_C : r_rows);
        col_c    = (CNT_W'(r_col) >= eff_cols) ? COL_W'(eff_cols - CNT_W'(1)) : r_col;
        row_c    = (CFG_W'(r_row) >= eff_rows) ? ROW_W'(eff_rows - CFG_W'(1)) : r_row;
        last_col = (CNT_W'(col_c) + CNT_W'(1)) >= eff_cols;
        last_row = (CFG_W'(row_c) + CFG_W'(1)) >= eff_rows;
    end

    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_c + ROW_W'(1);
        end else begin
            n_col = col_c + COL_W'(1);
            n_row = row_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col             = col_c;
    assign o_flags.first_row = (row_c == '0);
    assign o_flags.first_col = (col_c == '0);
    assign o_flags.last_col  = last_col;
    assign o_flags.last_row  = last_row;

endmodule

### rtl/chamfer_distance_first_pass.sv
// First pass of an 8-connected chamfer distance transform on a raster pixel
// stream. Takes one pixel per clock unless the output stalls and gives one
// result per pixel, registered out of the distance stage. The previous row
// of distances sits in a line store of MAX_COLUMNS entries with two
// registered read ports: the pixel's column and the one to its right are read
// as it is accepted, and its distance is written back as it leaves the
// distance stage, forwarded when the next pixel reads that entry at the same
// edge. The user sets rows and columns through the config port while the
// block is idle, which the block does not enforce; zero counts as one,
// oversize values count as the limit. Distances saturate at all ones;
// running min and max restart after the frame's last pixel (o_frame_end).
module chamfer_distance_first_pass #(
    parameter int MAX_COLUMNS = cdfp_pkg::MAX_COLUMNS_DEF,
    parameter int DIST_BITS   = cdfp_pkg::DIST_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [cdfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cdfp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [cdfp_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [DIST_BITS-1:0]           o_distance,
    output logic [DIST_BITS-1:0]           o_running_min,
    output logic [DIST_BITS-1:0]           o_running_max,
    output logic                           o_frame_end
);
    import cdfp_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    logic             accept, b_adv;
    logic [COL_W-1:0] a_col, a_col_nx;
    t_pos_flags       a_flags;

    logic                 r_b_valid;
    logic                 r_b_nz;
    logic [COL_W-1:0]     r_b_col;
    t_pos_flags           r_b_flags;
    logic                 r_b_fwd_a, r_b_fwd_b;
    logic [DIST_BITS-1:0] r_b_fwd_data;

    logic [DIST_BITS-1:0] rd_a, rd_b;
    logic [DIST_BITS-1:0] up, upr, ul, lf, m_lo, m_hi, m_all, cur_dist;
    logic [DIST_BITS-1:0] n_min, n_max;

    logic [DIST_BITS-1:0] r_left, r_ul, r_min, r_max;
    logic                 r_o_valid;

    assign b_adv    = r_b_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_b_valid || b_adv;
    assign accept   = i_valid && o_ready;
    assign a_col_nx = a_col + COL_W'(1);

    cdfp_raster_ctr #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W)
    ) u_raster_ctr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_col       (a_col),
        .o_flags     (a_flags)
    );

    cdfp_line_store #(
        .DEPTH  (MAX_COLUMNS),
        .DATA_W (DIST_BITS),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr_a (a_col),
        .i_rd_addr_b (a_col_nx),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b),
        .i_wr_en     (b_adv),
        .i_wr_addr   (r_b_col),
        .i_wr_data   (cur_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    // entry written at the same edge as the read: take the new value
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_nz       <= (i_pixel != '0);
            r_b_col      <= a_col;
            r_b_flags    <= a_flags;
            r_b_fwd_a    <= b_adv && (r_b_col == a_col);
            r_b_fwd_b    <= b_adv && (r_b_col == a_col_nx);
            r_b_fwd_data <= cur_dist;
        end
    end

    always_comb begin
        up    = r_b_flags.first_row ? '0 : (r_b_fwd_a ? r_b_fwd_data : rd_a);
        upr   = (r_b_flags.first_row || r_b_flags.last_col) ? '0 :
                (r_b_fwd_b ? r_b_fwd_data : rd_b);
        ul    = (r_b_flags.first_row || r_b_flags.first_col) ? '0 : r_ul;
        lf    = r_b_flags.first_col ? '0 : r_left;
        m_lo  = (ul < up) ? ul : up;
        m_hi  = (upr < lf) ? upr : lf;
        m_all = (m_lo < m_hi) ? m_lo : m_hi;
        if (!r_b_nz) begin
            cur_dist = '0;
        end else begin
            cur_dist = (m_all == DIST_MAX) ? DIST_MAX : m_all + DIST_BITS'(1);
        end
        n_min = (cur_dist < r_min) ? cur_dist : r_min;
        n_max = (cur_dist > r_max) ? cur_dist : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ul   <= '0;
            r_min  <= DIST_MAX;
            r_max  <= '0;
        end else if (b_adv) begin
            r_left <= cur_dist;
            r_ul   <= up;
            if (r_b_flags.last_col && r_b_flags.last_row) begin
                r_min <= DIST_MAX;
                r_max <= '0;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            o_distance    <= cur_dist;
            o_running_min <= n_min;
            o_running_max <= n_max;
            o_frame_end   <= r_b_flags.last_col && r_b_flags.last_row;
        end
    end

    assign o_valid = r_o_valid;

endmodule

### test/tb_chamfer_distance_first_pass.sv
module tb_chamfer_distance_first_pass;
    timeunit 1ns;
    timeprecision 1ps;

    import cdfp_pkg::*;

    localparam int DW             = DIST_BITS_DEF;
    localparam int MAXC           = MAX_COLUMNS_DEF;
    localparam int DIST_MAX       = (1 << DW) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 270;
    localparam int WIDE_SPAN      = 96;
    localparam int TALL_SPAN      = 64;

    // 3 x 4 frame: extremes and alternating bit patterns
    localparam logic [PIXEL_W-1:0] GRID_3X4 [12] = '{
        16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
        16'h0001, 16'h5555, 16'hAAAA, 16'h0001,
        16'h0000, 16'h0001, 16'hFFFF, 16'h0007
    };

    typedef struct packed {
        logic [DW-1:0] distance;
        logic [DW-1:0] run_min;
        logic [DW-1:0] run_max;
        logic          frame_end;
    } t_dist_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [PIXEL_W-1:0]   i_pixel     = '0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [DW-1:0]        o_distance;
    logic [DW-1:0]        o_running_min;
    logic [DW-1:0]        o_running_max;
    logic                 o_frame_end;

    chamfer_distance_first_pass dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_distance    (o_distance),
        .o_running_min (o_running_min),
        .o_running_max (o_running_max),
        .o_frame_end   (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    // Model of the transform
    logic [DW-1:0]    line_store [MAXC];
    logic [DW-1:0]    left_dist;
    logic [DW-1:0]    upleft_dist;
    int               pos_col;
    int               pos_row;
    logic [DW-1:0]    frame_min;
    logic [DW-1:0]    frame_max;
    logic [CFG_W-1:0] cfg_rows;
    logic [CFG_W-1:0] cfg_cols;

    logic [PIXEL_W-1:0] pixel_q [$];
    t_dist_result       due_results [$];
    t_dist_result       head;
    int                 mismatch_count = 0;
    int                 tx_gap         = 0;
    int                 rx_stall       = 0;
    int                 idle_cycles    = 0;
    bit                 tx_calm        = 1'b0;
    bit                 rx_calm        = 1'b0;

    function automatic int eff_size(input int v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic t_dist_result predict_pixel(input logic [PIXEL_W-1:0] pix);
        int rows, cols, col, row, up, upr, ul, lf, m, d_val;
        bit last_col, last_row;
        t_dist_result res;
        rows = eff_size(int'(cfg_rows), ROW_LIMIT);
        cols = eff_size(int'(cfg_cols), MAXC);
        col  = (pos_col >= cols) ? cols - 1 : pos_col;
        row  = (pos_row >= rows) ? rows - 1 : pos_row;
        last_col = (col + 1 >= cols);
        last_row = (row + 1 >= rows);
        up = 0; upr = 0; ul = 0; lf = 0; d_val = 0;
        if (row > 0) begin
            up = line_store[col];
            if (!last_col) upr = line_store[col + 1];
            if (col > 0) ul = upleft_dist;
        end
        if (col > 0) lf = left_dist;
        if (pix != 0) begin
            m = ul;
            if (up < m) m = up;
            if (upr < m) m = upr;
            if (lf < m) m = lf;
            d_val = (m >= DIST_MAX) ? DIST_MAX : m + 1;
        end
        line_store[col] = d_val[DW-1:0];
        upleft_dist     = up[DW-1:0];
        left_dist       = d_val[DW-1:0];
        if (d_val < frame_min) frame_min = d_val[DW-1:0];
        if (d_val > frame_max) frame_max = d_val[DW-1:0];
        res.distance  = d_val[DW-1:0];
        res.run_min   = frame_min;
        res.run_max   = frame_max;
        res.frame_end = last_col && last_row;
        if (last_col) begin
            pos_col = 0;
            if (last_row) begin
                pos_row   = 0;
                frame_min = DIST_MAX[DW-1:0];
                frame_max = '0;
            end else begin
                pos_row = row + 1;
            end
        end else begin
            pos_col = col + 1;
            pos_row = row;
        end
        return res;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIXEL_W-1:0] gen_pixel(input int density);
        int s;
        if ($urandom_range(0, 99) >= density) return '0;
        s = $urandom_range(0, 9);
        if (s < 2) return 16'hFFFF;
        if (s < 5) return PIXEL_W'($urandom_range(1, 65535));
        return PIXEL_W'($urandom_range(1, 15));
    endfunction

    // Frame dimension: mostly small, sometimes zero, the limit or oversize
    function automatic logic [CFG_W-1:0] pick_dim(input int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 8) return CFG_W'(1024);
        if (r < 11) return CFG_W'($urandom_range(1025, 2047));
        return CFG_W'($urandom_range(1, top));
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_IMAGE_ROWS) cfg_rows = val;
        else cfg_cols = val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready) due_results.push_back(predict_pixel(i_pixel));
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    i_pixel <= pixel_q.pop_front();
                    i_valid <= 1'b1;
                    tx_gap = tx_calm ? 0 : gap_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall = gap_len();
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $display("t=%0t unexpected result: expected none, actual distance %0d",
                         $time, o_distance);
                mismatch_count++;
            end else begin
                head = due_results.pop_front();
                check_field("distance", int'(head.distance), int'(o_distance));
                check_field("running_min", int'(head.run_min), int'(o_running_min));
                check_field("running_max", int'(head.run_max), int'(o_running_max));
                check_field("frame_end", int'(head.frame_end), int'(o_frame_end));
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int rand_items, n, rem, rows_e, cols_e, c, r, dens;
        bit do_rows, do_cols;
        logic [CFG_W-1:0] val;

        cfg_rows    = CFG_W'(1);
        cfg_cols    = CFG_W'(1);
        left_dist   = '0;
        upleft_dist = '0;
        pos_col     = 0;
        pos_row     = 0;
        frame_min   = DIST_MAX[DW-1:0];
        frame_max   = '0;
        rand_items  = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 1 x 1 frames straight out of reset
        pixel_q.push_back(16'h0000);
        pixel_q.push_back(16'hFFFF);
        pixel_q.push_back(16'h0001);
        wait_idle();

        write_reg(REG_IMAGE_ROWS, CFG_W'(3));
        write_reg(REG_IMAGE_COLS, CFG_W'(4));
        foreach (GRID_3X4[k]) pixel_q.push_back(GRID_3X4[k]);
        wait_idle();

        // zero sizes behave as one
        write_reg(REG_IMAGE_ROWS, '0);
        write_reg(REG_IMAGE_COLS, '0);
        pixel_q.push_back(16'h0002);
        pixel_q.push_back(16'h0000);
        wait_idle();

        // size changes part way through a frame
        write_reg(REG_IMAGE_ROWS, CFG_W'(2));
        write_reg(REG_IMAGE_COLS, CFG_W'(3));
        repeat (4) pixel_q.push_back(16'h00FF);
        wait_idle();
        write_reg(REG_IMAGE_COLS, CFG_W'(1));
        pixel_q.push_back(16'h0100);
        pixel_q.push_back(16'h0003);
        wait_idle();
        write_reg(REG_IMAGE_ROWS, CFG_W'(1));
        pixel_q.push_back(16'h7FFF);
        wait_idle();

        // oversize width counts as the limit, then the row is cut short
        write_reg(REG_IMAGE_ROWS, CFG_W'(2));
        write_reg(REG_IMAGE_COLS, CFG_W'(2047));
        repeat (WIDE_SPAN) pixel_q.push_back(gen_pixel(85));
        wait_idle();
        write_reg(REG_IMAGE_COLS, CFG_W'(WIDE_SPAN + 1));
        repeat (WIDE_SPAN + 2) pixel_q.push_back(gen_pixel(85));
        wait_idle();

        // oversize height counts as the limit, then the frame is cut short
        write_reg(REG_IMAGE_ROWS, CFG_W'(2047));
        write_reg(REG_IMAGE_COLS, CFG_W'(1));
        repeat (TALL_SPAN) pixel_q.push_back(gen_pixel(70));
        wait_idle();
        write_reg(REG_IMAGE_ROWS, CFG_W'(TALL_SPAN + 1));
        pixel_q.push_back(gen_pixel(70));
        wait_idle();

        while (rand_items < RANDOM_ITEMS) begin
            wait_idle();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            // some phases leave the registers unchanged
            if ($urandom_range(0, 9) >= 2) begin
                do_rows = ($urandom_range(0, 9) < 7);
                do_cols = !do_rows || ($urandom_range(0, 9) < 7);
                if (do_rows) write_reg(REG_IMAGE_ROWS, pick_dim(6));
                if (do_cols) begin
                    // mid-frame the row may only shrink, so the line store is always valid
                    if (pos_col == 0 && pos_row == 0) val = pick_dim(8);
                    else val = CFG_W'($urandom_range(0, eff_size(int'(cfg_cols), MAXC)));
                    write_reg(REG_IMAGE_COLS, val);
                end
            end
            rows_e = eff_size(int'(cfg_rows), ROW_LIMIT);
            cols_e = eff_size(int'(cfg_cols), MAXC);
            c   = (pos_col >= cols_e) ? cols_e - 1 : pos_col;
            r   = (pos_row >= rows_e) ? rows_e - 1 : pos_row;
            rem = (rows_e - 1 - r) * cols_e + (cols_e - c);
            if (rem <= 64 && $urandom_range(0, 9) < 7) n = rem;
            else n = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       dens = 100;
                1:       dens = 85;
                2:       dens = 50;
                default: dens = 10;
            endcase
            repeat (n) pixel_q.push_back(gen_pixel(dens));
            rand_items += n;
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/cdfp_pkg.sv
rtl/cdfp_line_store.sv
rtl/cdfp_raster_ctr.sv
rtl/chamfer_distance_first_pass.sv
test/tb_chamfer_distance_first_pass.sv
